// ----- design/settling_velocity_solver_top_assert.svh -----
// assertion macros used by the solver top level
`ifndef SETTLING_VELOCITY_SOLVER_TOP_ASSERT_SVH
`define SETTLING_VELOCITY_SOLVER_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SVS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svs assertion failed");

// consequent must hold in the cycle after the antecedent
`define SVS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svs assertion failed");

`endif

// ----- design/svs_pkg.sv -----
// types and constants of the settling velocity solver
`default_nettype none
package svs_pkg;

    localparam int SVS_VEL_FRAC_BITS = 32;

    localparam logic [2:0] CFG_FLUID_DENSITY = 3'd0;
    localparam logic [2:0] CFG_VISCOSITY     = 3'd1;
    localparam logic [2:0] CFG_GRAVITY       = 3'd2;
    localparam logic [2:0] CFG_TOLERANCE     = 3'd3;
    localparam logic [2:0] CFG_ITER_LIMIT    = 3'd4;
    localparam logic [2:0] CFG_INIT_GUESS    = 3'd5;

    localparam logic [1:0] STAT_CONVERGED  = 2'd0;
    localparam logic [1:0] STAT_LIMIT      = 2'd1;
    localparam logic [1:0] STAT_NOT_DENSER = 2'd2;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT,
        OP_DIV3
    } alu_op_t;

    typedef struct packed {
        alu_op_t     op;
        logic [63:0] a;
        logic [79:0] b;
        logic [63:0] r0;
        logic [6:0]  steps;
    } alu_req_t;

endpackage
`default_nettype wire

// ----- design/svs_channels.sv -----
// channel interfaces of the settling velocity solver
`default_nettype none
interface svs_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] grain_diameter;
    logic [23:0] solid_density;
    modport source (output valid, output grain_diameter, output solid_density, input ready);
    modport sink (input valid, input grain_diameter, input solid_density, output ready);
endinterface

interface svs_out_if;
    logic        valid;
    logic        ready;
    logic [39:0] fall_velocity;
    logic [5:0]  iterations_used;
    logic [1:0]  status;
    modport source (output valid, output fall_velocity, output iterations_used,
                    output status, input ready);
    modport sink (input valid, input fall_velocity, input iterations_used,
                  input status, output ready);
endinterface

interface svs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [39:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- design/svs_alu.sv -----
// shared shift-add multiplier, restoring divider, divide by three and square root unit
`default_nettype none
module svs_alu
    import svs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  alu_req_t         req,
    output logic             busy,
    output logic             done,
    output logic [95:0]      result
);

    alu_op_t     op_reg;
    logic [63:0] a_reg;
    logic [95:0] p_reg;
    logic [63:0] r_reg;
    logic [63:0] q_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [64:0] mul_sum;
    logic [65:0] sub_t;
    logic [65:0] sub_d;
    logic [65:0] sub_diff;
    logic        sub_ge;
    logic [63:0] r_next;
    logic [1:0]  d3_rem;
    logic [2:0]  d3_t;
    logic [15:0] d3_q;

    // one adder for multiply, one compare/subtract for divide and root
    always_comb
    begin
        mul_sum = {1'b0, p_reg[95:32]} + (p_reg[0] ? {1'b0, a_reg} : 65'd0);
        if (op_reg == OP_SQRT)
        begin
            sub_t = {r_reg, p_reg[95:94]};
            sub_d = {q_reg, 2'b01};
        end
        else
        begin
            sub_t = {1'b0, r_reg, p_reg[95]};
            sub_d = {2'b00, a_reg};
        end
        sub_ge   = sub_t >= sub_d;
        sub_diff = sub_t - sub_d;
        r_next   = sub_ge ? sub_diff[63:0] : sub_t[63:0];
        // divide by three, sixteen dividend bits per step
        d3_rem = r_reg[1:0];
        d3_t   = '0;
        d3_q   = '0;
        for (int i = 15; i >= 0; i--)
        begin
            d3_t    = {d3_rem, p_reg[80 + i]};
            d3_q[i] = (d3_t >= 3'd3);
            d3_rem  = d3_q[i] ? 2'(d3_t - 3'd3) : d3_t[1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= OP_MUL;
            a_reg    <= '0;
            p_reg    <= '0;
            r_reg    <= '0;
            q_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                op_reg   <= req.op;
                a_reg    <= req.a;
                r_reg    <= req.r0;
                q_reg    <= '0;
                cnt_reg  <= req.steps;
                busy_reg <= 1'b1;
                case (req.op)
                    OP_MUL:  p_reg <= {64'd0, req.b[31:0]};
                    OP_DIV:  p_reg <= {req.b[63:0], 32'd0};
                    OP_SQRT: p_reg <= {req.b, 16'd0};
                    OP_DIV3: p_reg <= {req.b[63:0], 32'd0};
                    default: p_reg <= '0;
                endcase
            end
            else if (busy_reg)
            begin
                case (op_reg)
                    OP_MUL:
                    begin
                        p_reg <= {mul_sum, p_reg[31:1]};
                    end
                    OP_DIV:
                    begin
                        p_reg <= {p_reg[94:0], 1'b0};
                        r_reg <= r_next;
                        q_reg <= {q_reg[62:0], sub_ge};
                    end
                    OP_SQRT:
                    begin
                        p_reg <= {p_reg[93:0], 2'b00};
                        r_reg <= r_next;
                        q_reg <= {q_reg[62:0], sub_ge};
                    end
                    OP_DIV3:
                    begin
                        p_reg <= {p_reg[79:0], 16'd0};
                        r_reg <= {62'd0, d3_rem};
                        q_reg <= {q_reg[47:0], d3_q};
                    end
                    default:
                    begin
                        p_reg <= p_reg;
                    end
                endcase
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = (op_reg == OP_MUL) ? p_reg : {32'd0, q_reg};

endmodule
`default_nettype wire

// ----- design/settling_velocity_solver_top.sv -----
// settling velocity solver: top level with sequencer and configuration registers
//
// in_ch carries one grain (diameter, solid density) per transaction; out_ch
// returns one transaction per grain: fall velocity, refinements used, status.
// cfg writes a register by index (0 fluid density, 1 viscosity, 2 gravity,
// 3 tolerance, 4 iteration limit, 5 initial guess); it is always ready and
// is meant to be written only while the block is idle.
// All arithmetic runs on one shared unit (shift-add multiply, restoring
// divide, divide by three, bitwise square root) stepped by the sequencer below.
// A grain not denser than the fluid skips the unit and goes from idle
// through S_DONE to the output register. Otherwise setup runs a divide, two
// multiplies and a divide by three on the unit, and each velocity evaluation
// a multiply, a divide, a multiply and a square root; the iteration limit
// resets to 10. in_ch is ready only in idle.
// The result sits in an output register; a new grain is taken while it
// waits, and the sequencer holds its finished result until the register
// frees up when the receiver stalls.
// Reset clears the sequencer and output valid and restores register defaults.
`default_nettype none
`include "settling_velocity_solver_top_assert.svh"
module settling_velocity_solver_top
    import svs_pkg::*;
#(
    parameter int VEL_FRAC_BITS = SVS_VEL_FRAC_BITS
)
(
    input wire logic  clk,
    input wire logic  rst_n,
    svs_in_if.sink    in_ch,
    svs_out_if.source out_ch,
    svs_cfg_if.sink   cfg
);

    localparam int WD_SHIFT  = VEL_FRAC_BITS - 16;
    localparam int RAD_SHIFT = 80 - 2 * VEL_FRAC_BITS;
    localparam logic [55:0] WD_MAX = '1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SM1,
        S_SG,
        S_KMUL,
        S_KDIV,
        S_WD,
        S_DEN,
        S_INVC,
        S_RAD,
        S_ROOT,
        S_CHECK,
        S_DONE
    } state_t;

    // configuration registers
    logic [23:0] fluid_reg;
    logic [39:0] nu_reg;
    logic [31:0] grav_reg;
    logic [31:0] tol_reg;
    logic [5:0]  limit_reg;
    logic [39:0] guess_reg;

    // sequencer state and working values
    state_t      state_reg;
    logic [31:0] d_reg;
    logic [63:0] k_reg;
    logic [55:0] wd_reg;
    logic [39:0] ws_reg;
    logic [39:0] nxt_reg;
    logic [5:0]  iter_reg;
    logic        light_reg;
    logic        start_reg;
    alu_req_t    req_reg;

    // output register
    logic        out_valid_reg;
    logic [39:0] vel_out_reg;
    logic [5:0]  iter_out_reg;
    logic [1:0]  stat_out_reg;

    logic        alu_busy;
    logic        alu_done;
    logic [95:0] alu_res;

    svs_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_reg),
        .req    (req_reg),
        .busy   (alu_busy),
        .done   (alu_done),
        .result (alu_res)
    );

    logic [23:0] rf;
    logic        in_acc;
    logic [95:0] wd_wide;
    logic [55:0] wd_val;
    logic [95:0] rad_wide;
    logic [79:0] rad_val;
    logic [63:0] sg_val;
    logic [63:0] kpre_val;
    logic [63:0] wd64;
    logic [63:0] nu64;
    logic [63:0] num5;
    logic [63:0] den_val;
    logic [39:0] vdiff;
    logic        keep_going;
    logic        out_free;

    always_comb
    begin
        rf       = (fluid_reg == 24'd0) ? 24'd1 : fluid_reg;
        in_acc   = in_ch.valid && (state_reg == S_IDLE);
        // saturating rescales of the unit's product
        sg_val   = (alu_res[95:88] != 8'd0) ? '1 : alu_res[87:24];
        kpre_val = (alu_res[95:78] != 18'd0) ? '1 : alu_res[77:14];
        wd_wide  = alu_res >> WD_SHIFT;
        wd_val   = (wd_wide[95:56] != 40'd0) ? WD_MAX : wd_wide[55:0];
        rad_wide = alu_res >> RAD_SHIFT;
        rad_val  = (rad_wide[95:80] != 16'd0) ? '1 : rad_wide[79:0];
        // 5 wd over 7 wd + 180 nu gives 1/C
        wd64     = {8'd0, wd_reg};
        nu64     = {24'd0, nu_reg};
        num5     = (wd64 << 2) + wd64;
        den_val  = (wd64 << 3) - wd64 + (nu64 << 7) + (nu64 << 5) + (nu64 << 4) + (nu64 << 2);
        vdiff    = (ws_reg > nxt_reg) ? ws_reg - nxt_reg : nxt_reg - ws_reg;
        keep_going = (iter_reg < limit_reg) && (vdiff > {8'd0, tol_reg});
        out_free = !out_valid_reg || out_ch.ready;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fluid_reg <= 24'd256000;
            nu_reg    <= 40'd281474977;
            grav_reg  <= 32'd164584489;
            tol_reg   <= 32'd42950;
            limit_reg <= 6'd10;
            guess_reg <= 40'd429496730;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_FLUID_DENSITY: fluid_reg <= cfg.data[23:0];
                CFG_VISCOSITY:     nu_reg    <= cfg.data;
                CFG_GRAVITY:       grav_reg  <= cfg.data[31:0];
                CFG_TOLERANCE:     tol_reg   <= cfg.data[31:0];
                CFG_ITER_LIMIT:    limit_reg <= cfg.data[5:0];
                CFG_INIT_GUESS:    guess_reg <= cfg.data;
                default:           fluid_reg <= fluid_reg;
            endcase
        end
    end

    // sequencer: launches unit operations one at a time and steps on their done pulses
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            req_reg       <= '0;
            d_reg         <= '0;
            k_reg         <= '0;
            wd_reg        <= '0;
            ws_reg        <= '0;
            nxt_reg       <= '0;
            iter_reg      <= '0;
            light_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            vel_out_reg   <= '0;
            iter_out_reg  <= '0;
            stat_out_reg  <= STAT_CONVERGED;
        end
        else
        begin
            start_reg <= 1'b0;
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        d_reg    <= in_ch.grain_diameter;
                        iter_reg <= '0;
                        if (in_ch.solid_density <= rf)
                        begin
                            light_reg <= 1'b1;
                            nxt_reg   <= '0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            light_reg     <= 1'b0;
                            start_reg     <= 1'b1;
                            req_reg.op    <= OP_DIV;
                            req_reg.a     <= {40'd0, rf};
                            req_reg.b     <= {24'd0, in_ch.solid_density - rf, 32'd0};
                            req_reg.r0    <= '0;
                            req_reg.steps <= 7'd64;
                            state_reg     <= S_SM1;
                        end
                    end
                end
                S_SM1:
                begin
                    if (alu_done)
                    begin
                        start_reg     <= 1'b1;
                        req_reg.op    <= OP_MUL;
                        req_reg.a     <= alu_res[63:0];
                        req_reg.b     <= {48'd0, grav_reg};
                        req_reg.steps <= 7'd32;
                        state_reg     <= S_SG;
                    end
                end
                S_SG:
                begin
                    if (alu_done)
                    begin
                        start_reg     <= 1'b1;
                        req_reg.op    <= OP_MUL;
                        req_reg.a     <= sg_val;
                        req_reg.b     <= {48'd0, d_reg};
                        req_reg.steps <= 7'd32;
                        state_reg     <= S_KMUL;
                    end
                end
                S_KMUL:
                begin
                    if (alu_done)
                    begin
                        // divide by three, sixteen bits per step
                        start_reg     <= 1'b1;
                        req_reg.op    <= OP_DIV3;
                        req_reg.b     <= {16'd0, kpre_val};
                        req_reg.r0    <= '0;
                        req_reg.steps <= 7'd4;
                        state_reg     <= S_KDIV;
                    end
                end
                S_KDIV:
                begin
                    if (alu_done)
                    begin
                        k_reg         <= alu_res[63:0];
                        ws_reg        <= guess_reg;
                        start_reg     <= 1'b1;
                        req_reg.op    <= OP_MUL;
                        req_reg.a     <= {24'd0, guess_reg};
                        req_reg.b     <= {48'd0, d_reg};
                        req_reg.steps <= 7'd32;
                        state_reg     <= S_WD;
                    end
                end
                S_WD:
                begin
                    if (alu_done)
                    begin
                        wd_reg <= wd_val;
                        if (wd_val == 56'd0)
                        begin
                            // zero product gives zero velocity
                            nxt_reg   <= '0;
                            state_reg <= S_CHECK;
                        end
                        else
                        begin
                            state_reg <= S_DEN;
                        end
                    end
                end
                S_DEN:
                begin
                    start_reg     <= 1'b1;
                    req_reg.op    <= OP_DIV;
                    req_reg.a     <= den_val;
                    req_reg.b     <= '0;
                    req_reg.r0    <= num5;
                    req_reg.steps <= 7'd32;
                    state_reg     <= S_INVC;
                end
                S_INVC:
                begin
                    if (alu_done)
                    begin
                        start_reg     <= 1'b1;
                        req_reg.op    <= OP_MUL;
                        req_reg.a     <= k_reg;
                        req_reg.b     <= {48'd0, alu_res[31:0]};
                        req_reg.steps <= 7'd32;
                        state_reg     <= S_RAD;
                    end
                end
                S_RAD:
                begin
                    if (alu_done)
                    begin
                        start_reg     <= 1'b1;
                        req_reg.op    <= OP_SQRT;
                        req_reg.b     <= rad_val;
                        req_reg.r0    <= '0;
                        req_reg.steps <= 7'd40;
                        state_reg     <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    if (alu_done)
                    begin
                        nxt_reg   <= alu_res[39:0];
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (keep_going)
                    begin
                        iter_reg      <= iter_reg + 6'd1;
                        ws_reg        <= nxt_reg;
                        start_reg     <= 1'b1;
                        req_reg.op    <= OP_MUL;
                        req_reg.a     <= {24'd0, nxt_reg};
                        req_reg.b     <= {48'd0, d_reg};
                        req_reg.steps <= 7'd32;
                        state_reg     <= S_WD;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        vel_out_reg   <= nxt_reg;
                        iter_out_reg  <= iter_reg;
                        if (light_reg)
                        begin
                            stat_out_reg <= STAT_NOT_DENSER;
                        end
                        else if (iter_reg >= limit_reg)
                        begin
                            stat_out_reg <= STAT_LIMIT;
                        end
                        else
                        begin
                            stat_out_reg <= STAT_CONVERGED;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ch.ready            = (state_reg == S_IDLE);
    assign cfg.ready              = 1'b1;
    assign out_ch.valid           = out_valid_reg;
    assign out_ch.fall_velocity   = vel_out_reg;
    assign out_ch.iterations_used = iter_out_reg;
    assign out_ch.status          = stat_out_reg;

    `SVS_ASSERT_NOW(a_start_unit_free, start_reg, !alu_busy)
    `SVS_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_reg != S_IDLE)
    `SVS_ASSERT_NOW(a_light_zero_vel, out_valid_reg && stat_out_reg == STAT_NOT_DENSER,
                    vel_out_reg == 40'd0 && iter_out_reg == 6'd0)
    `SVS_ASSERT_NOW(a_iter_in_limit, state_reg == S_CHECK, iter_reg <= limit_reg)

endmodule
`default_nettype wire

// ----- bench/settling_velocity_solver_top_tb.sv -----
// self-checking testbench for the settling velocity solver top level
`timescale 1ns / 1ps
module settling_velocity_solver_top_tb;
    import svs_pkg::*;

    localparam int VF = SVS_VEL_FRAC_BITS;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam logic [127:0] WD_CAP = (128'd1 << 56) - 1;

    typedef struct packed {
        logic [39:0] vel;
        logic [5:0]  iters;
        logic [1:0]  stat;
    } grain_result_t;

    // one directed grain: config set to apply first, stimulus, optional typed result
    typedef struct {
        int            cfg_set;
        logic [31:0]   diam;
        logic [23:0]   rho_s;
        bit            typed;
        grain_result_t res;
    } grain_row_t;

    logic clk;
    logic rst_n;

    svs_in_if  in_ch ();
    svs_out_if out_ch ();
    svs_cfg_if cfg ();

    settling_velocity_solver_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    // shadow copy of the configuration registers
    logic [23:0] rho_fluid;
    logic [39:0] visc;
    logic [31:0] grav;
    logic [31:0] tol;
    logic [5:0]  iter_lim;
    logic [39:0] guess;

    grain_result_t pending_velocities[$];
    int            mismatches;
    int            grains_sent;
    int            velocities_seen;
    int            send_idle_pct;
    int            recv_stall_pct;
    longint        cycles;

    // typed result handed from the sender to the monitor for the current grain
    bit            row_typed;
    grain_result_t row_res;

    // long receiver hold-off used to back the block up
    logic          hold_start;
    int            hold_left;

    grain_row_t    grain_rows[14];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [63:0] sat64(input logic [127:0] x);
        return (x[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : x[63:0];
    endfunction

    // one refinement of the drag law: velocity from the previous velocity
    function automatic logic [39:0] refine_velocity(input logic [39:0] w, input logic [31:0] d,
                                                    input logic [63:0] k);
        logic [127:0] wd;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] inv_drag;
        logic [127:0] rad;
        logic [127:0] cand;
        logic [39:0]  root;
        wd = 128'(sat64((128'(w) * 128'(d)) >> (VF - 16)));
        if (wd > WD_CAP)
            wd = WD_CAP;
        if (wd == 0)
            return 40'd0;
        num = 128'd5 * wd;
        den = 128'd7 * wd + 128'd180 * 128'(visc);
        inv_drag = (num << 32) / den;
        rad = (128'(k) * inv_drag) >> (80 - 2 * VF);
        root = 40'd0;
        for (int b = 39; b >= 0; b--)
        begin
            cand = 128'(root) | (128'd1 << b);
            if (cand * cand <= rad)
                root = cand[39:0];
        end
        return root;
    endfunction

    function automatic grain_result_t solve_grain(input logic [31:0] d, input logic [23:0] rs);
        grain_result_t r;
        logic [63:0]   rf;
        logic [63:0]   sm1;
        logic [63:0]   sg;
        logic [63:0]   k;
        logic [39:0]   w;
        logic [39:0]   nxt;
        logic [39:0]   diff;
        int            n;
        rf = (rho_fluid == 0) ? 64'd1 : 64'(rho_fluid);
        if (64'(rs) <= rf)
        begin
            r.vel = '0;
            r.iters = '0;
            r.stat = STAT_NOT_DENSER;
            return r;
        end
        sm1 = ((64'(rs) - rf) << 32) / rf;
        sg = sat64((128'(sm1) * 128'(grav)) >> 24);
        k = sat64((128'(sg) * 128'(d)) >> 14) / 64'd3;
        w = guess;
        nxt = refine_velocity(w, d, k);
        n = 0;
        while (n < iter_lim)
        begin
            diff = (w > nxt) ? w - nxt : nxt - w;
            if (diff <= 40'(tol))
                break;
            n++;
            w = nxt;
            nxt = refine_velocity(w, d, k);
        end
        r.vel = nxt;
        r.iters = 6'(n);
        r.stat = (n >= iter_lim) ? STAT_LIMIT : STAT_CONVERGED;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h", cycles, what, got, want);
    endtask

    // cycle counter and watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // monitor: predict on each input transaction, check each output transaction
    always @(posedge clk)
    begin
        grain_result_t want;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                pending_velocities.push_back(row_typed ? row_res :
                    solve_grain(in_ch.grain_diameter, in_ch.solid_density));
                grains_sent++;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                velocities_seen++;
                if (pending_velocities.size() == 0)
                begin
                    report_mismatch("unexpected result", 64'(out_ch.fall_velocity), 64'd0);
                end
                else
                begin
                    want = pending_velocities.pop_front();
                    if (out_ch.fall_velocity !== want.vel)
                        report_mismatch("fall_velocity", 64'(out_ch.fall_velocity),
                                        64'(want.vel));
                    if (out_ch.iterations_used !== want.iters)
                        report_mismatch("iterations_used", 64'(out_ch.iterations_used),
                                        64'(want.iters));
                    if (out_ch.status !== want.stat)
                        report_mismatch("status", 64'(out_ch.status), 64'(want.stat));
                end
            end
        end
    end

    // hold-off counter, runs in its own process
    always @(posedge clk)
    begin
        if (hold_start)
            hold_left <= 4000;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // receiver: random stalls plus the long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= (hold_left == 0) &&
                            !($urandom_range(99) < recv_stall_pct);
    end

    task automatic write_reg(input logic [2:0] idx, input logic [39:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        case (idx)
            CFG_FLUID_DENSITY: rho_fluid = val[23:0];
            CFG_VISCOSITY:     visc = val;
            CFG_GRAVITY:       grav = val[31:0];
            CFG_TOLERANCE:     tol = val[31:0];
            CFG_ITER_LIMIT:    iter_lim = val[5:0];
            CFG_INIT_GUESS:    guess = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // block is idle once every result is back and a short pause has passed
    task automatic wait_drained();
        while (pending_velocities.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_all(input logic [23:0] f, input logic [39:0] nu, input logic [31:0] g,
                             input logic [31:0] t, input logic [5:0] lim, input logic [39:0] w0);
        wait_drained();
        write_reg(CFG_FLUID_DENSITY, 40'(f));
        write_reg(CFG_VISCOSITY, nu);
        write_reg(CFG_GRAVITY, 40'(g));
        write_reg(CFG_TOLERANCE, 40'(t));
        write_reg(CFG_ITER_LIMIT, 40'(lim));
        write_reg(CFG_INIT_GUESS, w0);
    endtask

    // offer one grain, with random idle cycles in front of it
    task automatic send_grain(input logic [31:0] d, input logic [23:0] rs, input bit typed,
                              input grain_result_t res);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        row_typed <= typed;
        row_res <= res;
        in_ch.valid <= 1'b1;
        in_ch.grain_diameter <= d;
        in_ch.solid_density <= rs;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    function automatic logic [39:0] rand40();
        return {8'($urandom), 32'($urandom)};
    endfunction

    task automatic random_config(input int lim_max);
        logic [23:0] f;
        logic [31:0] t;
        case ($urandom_range(3))
            0: f = 24'd1;
            1: f = 24'hFFFFFF;
            2: f = 24'($urandom);
            default: f = 24'd256000;
        endcase
        case ($urandom_range(3))
            0: t = 32'd0;
            1: t = 32'hFFFF_FFFF;
            2: t = $urandom;
            default: t = 32'd42950;
        endcase
        write_all(f, ($urandom_range(1) != 0) ? rand40() : 40'd281474977,
                  ($urandom_range(1) != 0) ? $urandom : 32'd164584489, t,
                  6'($urandom_range(lim_max)),
                  ($urandom_range(1) != 0) ? rand40() : 40'd429496730);
    endtask

    task automatic random_grains(input int count);
        logic [31:0] d;
        logic [23:0] rs;
        for (int i = 0; i < count; i++)
        begin
            // mostly realistic grains denser than the fluid, the rest anything
            if ($urandom_range(99) < 80 && rho_fluid < 24'hFFFFFF)
            begin
                d = $urandom_range(32'd4295, 32'd429496730);
                rs = rho_fluid + 24'($urandom_range(1, 24'hFFFFFF - rho_fluid));
            end
            else
            begin
                d = ($urandom_range(9) == 0) ? 32'd1 : $urandom;
                rs = 24'($urandom);
            end
            send_grain(d, rs, 1'b0, '0);
        end
        in_ch.valid <= 1'b0;
    endtask

    initial
    begin
        int cur_set;
        int lim_max;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.grain_diameter = '0;
        in_ch.solid_density = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        out_ch.ready = 1'b0;
        hold_start = 1'b0;
        hold_left = 0;
        cycles = 0;
        mismatches = 0;
        grains_sent = 0;
        velocities_seen = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        row_typed = 1'b0;
        row_res = '0;
        rho_fluid = 24'd256000;
        visc = 40'd281474977;
        grav = 32'd164584489;
        tol = 32'd42950;
        iter_lim = 6'd10;
        guess = 40'd429496730;

        // directed grains; set 0 is the reset configuration
        grain_rows = '{
            '{0, 32'd1, 24'd0, 1'b1, '{40'd0, 6'd0, STAT_NOT_DENSER}},
            '{0, 32'hFFFF_FFFF, 24'd256000, 1'b1, '{40'd0, 6'd0, STAT_NOT_DENSER}},
            '{0, 32'd1, 24'd256001, 1'b0, '0},
            '{0, 32'hFFFF_FFFF, 24'hFFFFFF, 1'b0, '0},
            '{0, 32'd429496730, 24'd678400, 1'b0, '0},
            '{0, 32'd4294967, 24'd678400, 1'b0, '0},
            '{0, 32'h8000_0000, 24'h800000, 1'b0, '0},
            // limit of zero with a guess so small that the product w*d vanishes
            '{1, 32'd1, 24'd678400, 1'b1, '{40'd0, 6'd0, STAT_LIMIT}},
            '{1, 32'd42949673, 24'd678400, 1'b0, '0},
            // viscosity, gravity, guess and the first grain at their top to drive the saturating steps
            '{2, 32'hFFFF_FFFF, 24'hFFFFFF, 1'b0, '0},
            '{2, 32'd1, 24'd2, 1'b0, '0},
            // fluid density of zero acts as one; deepest iteration limit
            '{3, 32'd4294967, 24'd1, 1'b1, '{40'd0, 6'd0, STAT_NOT_DENSER}},
            '{3, 32'd4294967, 24'd678400, 1'b0, '0},
            '{3, 32'hFFFF_FFFF, 24'd2, 1'b0, '0}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur_set = 0;
        foreach (grain_rows[i])
        begin
            if (grain_rows[i].cfg_set != cur_set)
            begin
                in_ch.valid <= 1'b0;
                cur_set = grain_rows[i].cfg_set;
                case (cur_set)
                    1: write_all(24'd256000, 40'd281474977, 32'd164584489, 32'd42950,
                                 6'd0, 40'd1);
                    2: write_all(24'd1, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd0,
                                 6'd2, 40'hFF_FFFF_FFFF);
                    default: write_all(24'd0, 40'd281474977, 32'd164584489, 32'd42950,
                                       6'd63, 40'd429496730);
                endcase
            end
            send_grain(grain_rows[i].diam, grain_rows[i].rho_s, grain_rows[i].typed,
                       grain_rows[i].res);
        end
        in_ch.valid <= 1'b0;
        row_typed <= 1'b0;

        // random phases cycle through the idling modes; phase 5 holds the receiver off
        for (int ph = 0; ph < 9; ph++)
        begin
            lim_max = (ph == 8) ? 63 : 6;
            random_config(lim_max);
            if (ph == 8)
                write_reg(CFG_ITER_LIMIT, 40'd63);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            if (ph == 5)
            begin
                send_idle_pct = 0;
                write_reg(CFG_ITER_LIMIT, 40'd2);
                fork
                    random_grains(50);
                    begin
                        hold_start <= 1'b1;
                        @(posedge clk);
                        hold_start <= 1'b0;
                    end
                join
            end
            else
            begin
                random_grains((ph == 8) ? 5 : 50);
            end
        end

        while (pending_velocities.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("covered %0d grains and %0d results over directed extremes and nine random",
                 grains_sent, velocities_seen);
        $display("configurations with sender gaps, receiver stalls and one long hold-off");
        if (mismatches == 0 && pending_velocities.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/svs_pkg.sv
design/svs_channels.sv
design/svs_alu.sv
design/settling_velocity_solver_top.sv
bench/settling_velocity_solver_top_tb.sv
